[rtl/tte_pkg.sv]
// shared widths, constants, state and unit codes for the tick to elapsed time converter
package tte_pkg;

    // field widths
    localparam int unsigned TICK_W = 64;
    localparam int unsigned OP_W   = 3;
    localparam int unsigned FREQ_W = 34;

    // divisor width covers the tick frequency and the largest unit divisor (3.6e12)
    localparam int unsigned DSR_W = 42;

    // iteration counter, one quotient bit or one multiplier bit per cycle
    localparam int unsigned CNT_W = 6;
    localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(TICK_W - 1);

    // nanoseconds per second as a multiplier bit pattern
    localparam int unsigned     E9_W     = 30;
    localparam logic [E9_W-1:0] E9       = 30'd1000000000;
    localparam logic [CNT_W-1:0] MUL_LAST = CNT_W'(E9_W - 1);

    // tick frequency after reset
    localparam logic [FREQ_W-1:0] FREQ_RESET = 34'd1000000000;

    // unit selector codes; codes above hours also mean hours
    typedef enum logic [OP_W-1:0] {
        UNIT_NS  = 3'd0,
        UNIT_US  = 3'd1,
        UNIT_MS  = 3'd2,
        UNIT_S   = 3'd3,
        UNIT_MIN = 3'd4,
        UNIT_HR  = 3'd5
    } unit_t;

    // sequencer states
    typedef enum logic [2:0] {
        S_IDLE,
        S_DIV_Q,
        S_MUL_Q,
        S_MUL_R,
        S_DIV_R,
        S_ADD,
        S_DIV_U,
        S_FIN
    } state_t;

    // nanoseconds per selected unit; minutes and hours fold the two divisions into one
    function automatic logic [DSR_W-1:0] unit_divisor(input logic [OP_W-1:0] op);
        logic [DSR_W-1:0] dsr;
        case (op)
            UNIT_NS:  dsr = 42'd1;
            UNIT_US:  dsr = 42'd1000;
            UNIT_MS:  dsr = 42'd1000000;
            UNIT_S:   dsr = 42'd1000000000;
            UNIT_MIN: dsr = 42'd60000000000;
            default:  dsr = 42'd3600000000000;
        endcase
        return dsr;
    endfunction

endpackage

[rtl/tte_if.sv]
// valid/ready channel interfaces for query, answer and configuration transactions

interface tte_query_if;
    logic                        valid;
    logic                        ready;
    logic [tte_pkg::TICK_W-1:0]  tick_count;
    logic [tte_pkg::OP_W-1:0]    operation;

    modport source (output valid, output tick_count, output operation, input ready);
    modport sink   (input valid, input tick_count, input operation, output ready);
endinterface

interface tte_answer_if;
    logic                        valid;
    logic                        ready;
    logic [tte_pkg::TICK_W-1:0]  elapsed;

    modport source (output valid, output elapsed, input ready);
    modport sink   (input valid, input elapsed, output ready);
endinterface

interface tte_cfg_if;
    logic                        valid;
    logic                        ready;
    logic [tte_pkg::FREQ_W-1:0]  tick_freq;

    modport source (output valid, output tick_freq, input ready);
    modport sink   (input valid, input tick_freq, output ready);
endinterface

[rtl/tick_to_elapsed_time_converter.sv]
// tick count to elapsed time converter with one shared bit-serial divider and multiplier
//
// Usage:
//   query  : tick_count and operation (0 ns, 1 us, 2 ms, 3 s, 4 min, 5..7 h).
//            The first transaction after reset latches its tick_count as the epoch.
//   answer : elapsed time since the epoch in the selected unit, one per query.
//   cfg    : tick_freq in ticks per second; always ready, write only while idle.
// Sequence from query transaction to answer.valid:
//   a tick_freq of 0 skips to the output step (answer is 0);
//   otherwise the one-bit-per-cycle restoring divider runs 64-step passes for
//   ticks / freq and remainder * 1e9 / freq, with the shift-add multiplier's two
//   30-step passes between them; an add step follows, then a third 64-step pass
//   (ns / unit) for every unit but nanoseconds, then the output step.
// query.ready is high only while idle, so a new query is taken only once the
// last one has handed its result to the output register.
// A finished answer waits in the output register, and a new query is taken
// meanwhile; its own answer waits in the last step until the slot drains.
// Reset: tick_freq returns to 1e9, the epoch is forgotten, no answer is pending.
module tick_to_elapsed_time_converter (
    input  logic         clk,
    input  logic         rst_n,
    tte_query_if.sink    query,
    tte_answer_if.source answer,
    tte_cfg_if.sink      cfg
);

    // control registers
    tte_pkg::state_t                state_reg, state_next;
    logic [tte_pkg::CNT_W-1:0]      cnt_reg, cnt_next;
    logic                           epoch_valid_reg, epoch_valid_next;
    logic                           out_valid_reg, out_valid_next;
    logic [tte_pkg::FREQ_W-1:0]     freq_reg, freq_next;

    // datapath registers
    logic [tte_pkg::TICK_W-1:0]     epoch_reg, epoch_next;
    logic [tte_pkg::OP_W-1:0]       op_reg, op_next;
    logic [tte_pkg::TICK_W-1:0]     dvd_reg, dvd_next;
    logic [tte_pkg::DSR_W-1:0]      rem_reg, rem_next;
    logic [tte_pkg::DSR_W-1:0]      dsr_reg, dsr_next;
    logic [tte_pkg::TICK_W-1:0]     acc_reg, acc_next;
    logic [tte_pkg::TICK_W-1:0]     mcand_reg, mcand_next;
    logic [tte_pkg::TICK_W-1:0]     part_reg, part_next;
    logic [tte_pkg::TICK_W-1:0]     out_reg, out_next;

    // shared divider step
    logic [tte_pkg::DSR_W:0]        rem_sh;
    logic [tte_pkg::DSR_W+1:0]      diff;
    logic                           quo_bit;
    logic [tte_pkg::DSR_W-1:0]      step_rem;
    logic [tte_pkg::TICK_W-1:0]     step_quo;

    // shared multiplier step
    logic [tte_pkg::TICK_W-1:0]     mul_sum;

    // restoring division, one quotient bit per cycle
    always_comb
    begin
        rem_sh   = {rem_reg, dvd_reg[tte_pkg::TICK_W-1]};
        diff     = {1'b0, rem_sh} - {2'b00, dsr_reg};
        quo_bit  = ~diff[tte_pkg::DSR_W+1];
        step_rem = quo_bit ? diff[tte_pkg::DSR_W-1:0] : rem_sh[tte_pkg::DSR_W-1:0];
        step_quo = {dvd_reg[tte_pkg::TICK_W-2:0], quo_bit};
    end

    // shift-add by 1e9, one multiplier bit per cycle, wraps mod 2^64
    assign mul_sum = acc_reg +
        (tte_pkg::E9[cnt_reg[$clog2(tte_pkg::E9_W)-1:0]] ? mcand_reg : '0);

    // sequencer and datapath next values
    always_comb
    begin
        state_next       = state_reg;
        cnt_next         = cnt_reg;
        epoch_valid_next = epoch_valid_reg;
        out_valid_next   = out_valid_reg & ~answer.ready;
        freq_next        = freq_reg;
        epoch_next       = epoch_reg;
        op_next          = op_reg;
        dvd_next         = dvd_reg;
        rem_next         = rem_reg;
        dsr_next         = dsr_reg;
        acc_next         = acc_reg;
        mcand_next       = mcand_reg;
        part_next        = part_reg;
        out_next         = out_reg;

        // register write
        if (cfg.valid)
        begin
            freq_next = cfg.tick_freq;
        end

        unique case (state_reg)
            tte_pkg::S_IDLE:
            begin
                if (query.valid)
                begin
                    op_next  = query.operation;
                    rem_next = '0;
                    dsr_next = {{(tte_pkg::DSR_W - tte_pkg::FREQ_W){1'b0}}, freq_reg};
                    cnt_next = '0;
                    if (!epoch_valid_reg)
                    begin
                        epoch_next       = query.tick_count;
                        epoch_valid_next = 1'b1;
                        dvd_next         = '0;
                    end
                    else
                    begin
                        dvd_next = query.tick_count - epoch_reg;
                    end
                    // zero frequency reads as zero elapsed time
                    if (freq_reg == '0)
                    begin
                        dvd_next   = '0;
                        state_next = tte_pkg::S_FIN;
                    end
                    else
                    begin
                        state_next = tte_pkg::S_DIV_Q;
                    end
                end
            end

            // whole seconds' worth of ticks and the leftover ticks
            tte_pkg::S_DIV_Q:
            begin
                dvd_next = step_quo;
                rem_next = step_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tte_pkg::DIV_LAST)
                begin
                    mcand_next = step_quo;
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = tte_pkg::S_MUL_Q;
                end
            end

            // quotient times 1e9
            tte_pkg::S_MUL_Q:
            begin
                acc_next   = mul_sum;
                mcand_next = {mcand_reg[tte_pkg::TICK_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == tte_pkg::MUL_LAST)
                begin
                    part_next  = mul_sum;
                    mcand_next = {{(tte_pkg::TICK_W - tte_pkg::DSR_W){1'b0}}, rem_reg};
                    acc_next   = '0;
                    cnt_next   = '0;
                    state_next = tte_pkg::S_MUL_R;
                end
            end

            // remainder times 1e9, fits 64 bits for any frequency in range
            tte_pkg::S_MUL_R:
            begin
                acc_next   = mul_sum;
                mcand_next = {mcand_reg[tte_pkg::TICK_W-2:0], 1'b0};
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == tte_pkg::MUL_LAST)
                begin
                    dvd_next   = mul_sum;
                    rem_next   = '0;
                    dsr_next   = {{(tte_pkg::DSR_W - tte_pkg::FREQ_W){1'b0}}, freq_reg};
                    cnt_next   = '0;
                    state_next = tte_pkg::S_DIV_R;
                end
            end

            // fractional nanoseconds
            tte_pkg::S_DIV_R:
            begin
                dvd_next = step_quo;
                rem_next = step_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tte_pkg::DIV_LAST)
                begin
                    state_next = tte_pkg::S_ADD;
                end
            end

            // nanoseconds, then unit select
            tte_pkg::S_ADD:
            begin
                dvd_next = part_reg + dvd_reg;
                if (op_reg == tte_pkg::UNIT_NS)
                begin
                    state_next = tte_pkg::S_FIN;
                end
                else
                begin
                    rem_next   = '0;
                    dsr_next   = tte_pkg::unit_divisor(op_reg);
                    cnt_next   = '0;
                    state_next = tte_pkg::S_DIV_U;
                end
            end

            // nanoseconds down to the selected unit
            tte_pkg::S_DIV_U:
            begin
                dvd_next = step_quo;
                rem_next = step_rem;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == tte_pkg::DIV_LAST)
                begin
                    state_next = tte_pkg::S_FIN;
                end
            end

            // hand the result to the output register once it is free
            tte_pkg::S_FIN:
            begin
                if (!out_valid_reg || answer.ready)
                begin
                    out_next       = dvd_reg;
                    out_valid_next = 1'b1;
                    state_next     = tte_pkg::S_IDLE;
                end
            end

            default:
            begin
                state_next = tte_pkg::S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= tte_pkg::S_IDLE;
            cnt_reg         <= '0;
            epoch_valid_reg <= 1'b0;
            out_valid_reg   <= 1'b0;
            freq_reg        <= tte_pkg::FREQ_RESET;
        end
        else
        begin
            state_reg       <= state_next;
            cnt_reg         <= cnt_next;
            epoch_valid_reg <= epoch_valid_next;
            out_valid_reg   <= out_valid_next;
            freq_reg        <= freq_next;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        epoch_reg <= epoch_next;
        op_reg    <= op_next;
        dvd_reg   <= dvd_next;
        rem_reg   <= rem_next;
        dsr_reg   <= dsr_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        part_reg  <= part_next;
        out_reg   <= out_next;
    end

    // ports
    assign query.ready    = (state_reg == tte_pkg::S_IDLE);
    assign answer.valid   = out_valid_reg;
    assign answer.elapsed = out_reg;
    assign cfg.ready      = 1'b1;

endmodule

[rtl/tte_checker.sv]
// port-level checker for the tick to elapsed time converter and its bind
module tte_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       q_valid,
    input logic                       q_ready,
    input logic                       a_valid,
    input logic                       a_ready,
    input logic [tte_pkg::TICK_W-1:0] a_elapsed,
    input logic                       c_ready
);

    // a query transaction makes the block busy on the next cycle
    a_busy_after_query: assert property (@(posedge clk) disable iff (!rst_n)
        q_valid && q_ready |=> !q_ready)
        else $error("query ready still high after a query transaction");

    // ready only drops because a query was taken
    a_ready_drop_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(q_ready) |-> $past(q_valid))
        else $error("query ready dropped without a query transaction");

    // a stalled answer holds its value
    a_answer_hold: assert property (@(posedge clk) disable iff (!rst_n)
        a_valid && !a_ready |=> a_valid && $stable(a_elapsed))
        else $error("stalled answer changed or was dropped");

    // configuration writes are never back-pressured
    a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
        c_ready)
        else $error("configuration port not ready");

endmodule

bind tick_to_elapsed_time_converter tte_checker u_tte_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (query.valid),
    .q_ready   (query.ready),
    .a_valid   (answer.valid),
    .a_ready   (answer.ready),
    .a_elapsed (answer.elapsed),
    .c_ready   (cfg.ready)
);

[sim/testbench.sv]
`timescale 1ns / 1ps
// testbench for the tick to elapsed time converter: random and directed queries against a scoreboard
module testbench;

    // spare unit codes, both read as hours
    localparam logic [tte_pkg::OP_W-1:0]   UNIT_SPARE_6 = 3'd6;
    localparam logic [tte_pkg::OP_W-1:0]   UNIT_SPARE_7 = 3'd7;
    localparam logic [tte_pkg::FREQ_W-1:0] FREQ_MAX     = 34'h3_FFFF_FFFF;

    // unit scale factors
    localparam logic [tte_pkg::TICK_W-1:0] NS_PER_US = 64'd1000;
    localparam logic [tte_pkg::TICK_W-1:0] NS_PER_MS = 64'd1000000;
    localparam logic [tte_pkg::TICK_W-1:0] NS_PER_S  = 64'd1000000000;
    localparam logic [tte_pkg::TICK_W-1:0] S_PER_MIN = 64'd60;

    localparam int unsigned IDLE_LIMIT  = 5000;
    localparam int unsigned HOLD_CYCLES = 1000;
    localparam int unsigned SETTLE      = 300;
    localparam int          HOLD_PHASE  = 1;
    localparam int          NUM_PHASES  = 9;

    // expected answers and the converter state they follow from
    class elapsed_scoreboard;
        logic [tte_pkg::FREQ_W-1:0] freq;
        logic [tte_pkg::TICK_W-1:0] epoch;
        bit                         epoch_set;
        logic [tte_pkg::TICK_W-1:0] expected_elapsed[$];
        int unsigned                errors;
        int unsigned                answers;

        function new();
            freq      = tte_pkg::FREQ_RESET;
            epoch     = '0;
            epoch_set = 1'b0;
            errors    = 0;
            answers   = 0;
        endfunction

        function void set_freq(input logic [tte_pkg::FREQ_W-1:0] value);
            freq = value;
        endfunction

        // ticks to nanoseconds as quotient and remainder, products wrap at 64 bits
        function logic [tte_pkg::TICK_W-1:0] ticks_to_ns(
            input logic [tte_pkg::TICK_W-1:0] ticks);
            logic [tte_pkg::TICK_W-1:0] f;
            logic [tte_pkg::TICK_W-1:0] q;
            logic [tte_pkg::TICK_W-1:0] r;
            f = tte_pkg::TICK_W'(freq);
            if (f == '0)
                return '0;
            q = ticks / f;
            r = ticks % f;
            return q * NS_PER_S + (r * NS_PER_S) / f;
        endfunction

        // accepted query transaction: latch epoch on first, then predict
        function void note_query(input logic [tte_pkg::TICK_W-1:0] count,
                                 input logic [tte_pkg::OP_W-1:0] op);
            logic [tte_pkg::TICK_W-1:0] ns;
            logic [tte_pkg::TICK_W-1:0] secs;
            logic [tte_pkg::TICK_W-1:0] result;
            if (!epoch_set)
            begin
                epoch     = count;
                epoch_set = 1'b1;
            end
            ns   = ticks_to_ns(count - epoch);
            secs = ns / NS_PER_S;
            case (op)
                tte_pkg::UNIT_NS:  result = ns;
                tte_pkg::UNIT_US:  result = ns / NS_PER_US;
                tte_pkg::UNIT_MS:  result = ns / NS_PER_MS;
                tte_pkg::UNIT_S:   result = secs;
                tte_pkg::UNIT_MIN: result = secs / S_PER_MIN;
                default:           result = (secs / S_PER_MIN) / S_PER_MIN;
            endcase
            expected_elapsed.push_back(result);
        endfunction

        // accepted answer transaction against the oldest expectation
        function void check_answer(input logic [tte_pkg::TICK_W-1:0] actual);
            logic [tte_pkg::TICK_W-1:0] want;
            answers++;
            if (expected_elapsed.size() == 0)
            begin
                $display("%0t: unexpected answer, expected none, actual %0d", $time, actual);
                errors++;
            end
            else
            begin
                want = expected_elapsed.pop_front();
                if (actual !== want)
                begin
                    $display("%0t: elapsed mismatch, expected %0d, actual %0d",
                             $time, want, actual);
                    errors++;
                end
            end
        endfunction

        function int unsigned pending();
            return expected_elapsed.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    tte_query_if  query_ch();
    tte_answer_if answer_ch();
    tte_cfg_if    cfg_ch();

    elapsed_scoreboard board = new();

    int unsigned                tx_idle_pct   = 0;
    int unsigned                rx_idle_pct   = 0;
    int                         phase_no      = -1;
    int unsigned                hold_left     = 0;
    bit                         hold_done     = 1'b0;
    int unsigned                quiet_cycles  = 0;
    int unsigned                queries_sent  = 0;
    int unsigned                settings_used = 0;
    logic [tte_pkg::TICK_W-1:0] epoch_tick;

    tick_to_elapsed_time_converter i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .query  (query_ch),
        .answer (answer_ch),
        .cfg    (cfg_ch)
    );

    // 20 ns clock
    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // answer side: random idling, one long hold-off in the hold phase
    always @(posedge clk)
    begin
        if (hold_left != 0)
        begin
            answer_ch.ready <= 1'b0;
            hold_left       <= hold_left - 1;
        end
        else if (phase_no == HOLD_PHASE && !hold_done)
        begin
            answer_ch.ready <= 1'b0;
            hold_left       <= HOLD_CYCLES;
            hold_done       <= 1'b1;
        end
        else
        begin
            answer_ch.ready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    // answer monitor
    always @(posedge clk)
    begin
        if (rst_n && answer_ch.valid && answer_ch.ready)
            board.check_answer(answer_ch.elapsed);
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if ((query_ch.valid && query_ch.ready) || (answer_ch.valid && answer_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
            $display("FAIL tick_to_elapsed_time_converter");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // offer one query, with random idle cycles ahead of it
    task automatic offer_query(input logic [tte_pkg::TICK_W-1:0] count,
                               input logic [tte_pkg::OP_W-1:0] op);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            query_ch.valid <= 1'b0;
            @(posedge clk);
        end
        query_ch.valid      <= 1'b1;
        query_ch.tick_count <= count;
        query_ch.operation  <= op;
        do
            @(posedge clk);
        while (!query_ch.ready);
        board.note_query(count, op);
        queries_sent++;
    endtask

    // stop offering and wait until every answer is back
    task automatic wait_drained();
        query_ch.valid <= 1'b0;
        @(posedge clk);
        while (board.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // tick frequency register write
    task automatic write_freq(input logic [tte_pkg::FREQ_W-1:0] value);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.tick_freq <= value;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        board.set_freq(value);
        settings_used++;
    endtask

    // stimulus
    initial
    begin
        logic [tte_pkg::TICK_W-1:0] raw;
        logic [tte_pkg::TICK_W-1:0] delta;
        logic [tte_pkg::FREQ_W-1:0] freq_pick;
        int unsigned                pick;
        int                         n_items;

        query_ch.valid      = 1'b0;
        query_ch.tick_count = '0;
        query_ch.operation  = tte_pkg::UNIT_NS;
        cfg_ch.valid        = 1'b0;
        cfg_ch.tick_freq    = tte_pkg::FREQ_RESET;

        // epoch is zero on half the seeds, otherwise anywhere in the counter range
        epoch_tick = ($urandom_range(0, 1) == 0) ? '0 : {$urandom, $urandom};

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        tx_idle_pct = 34;
        rx_idle_pct <= 82;

        // directed: unit boundaries at the reset frequency
        offer_query(epoch_tick, tte_pkg::UNIT_NS);
        offer_query(epoch_tick + 64'd1, tte_pkg::UNIT_NS);
        offer_query(epoch_tick + 64'd999, tte_pkg::UNIT_US);
        offer_query(epoch_tick + 64'd1000, tte_pkg::UNIT_US);
        offer_query(epoch_tick + 64'd999999, tte_pkg::UNIT_MS);
        offer_query(epoch_tick + 64'd1000000, tte_pkg::UNIT_MS);
        offer_query(epoch_tick + 64'd999999999, tte_pkg::UNIT_S);
        offer_query(epoch_tick + 64'd1000000000, tte_pkg::UNIT_S);
        offer_query(epoch_tick + 64'd59999999999, tte_pkg::UNIT_MIN);
        offer_query(epoch_tick + 64'd60000000000, tte_pkg::UNIT_MIN);
        offer_query(epoch_tick + 64'd3599999999999, tte_pkg::UNIT_HR);
        offer_query(epoch_tick + 64'd3600000000000, tte_pkg::UNIT_HR);
        offer_query(epoch_tick + 64'd3600000000000, UNIT_SPARE_6);
        offer_query(epoch_tick + 64'd7200000000000, UNIT_SPARE_7);
        // counter one behind the epoch, and the halfway points
        offer_query(epoch_tick - 64'd1, tte_pkg::UNIT_NS);
        offer_query(epoch_tick - 64'd1, tte_pkg::UNIT_HR);
        offer_query(epoch_tick + 64'h8000_0000_0000_0000, tte_pkg::UNIT_US);
        offer_query(epoch_tick + 64'h7FFF_FFFF_FFFF_FFFF, UNIT_SPARE_7);
        // absolute extremes of the counter; the epoch must stay put
        offer_query(64'd0, tte_pkg::UNIT_S);
        offer_query('1, tte_pkg::UNIT_MS);
        offer_query(epoch_tick + 64'd1000000000, tte_pkg::UNIT_S);

        // random phases, one tick frequency each
        for (int p = 0; p < NUM_PHASES; p++)
        begin
            wait_drained();
            phase_no <= p;
            if (p < 3)
            begin
                tx_idle_pct = 34;
                rx_idle_pct <= 82;
            end
            else if (p < 6)
            begin
                tx_idle_pct = 82;
                rx_idle_pct <= 34;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct <= 0;
            end

            case (p)
                0: freq_pick = 34'd1;
                1: freq_pick = FREQ_MAX;
                2: freq_pick = '0;
                3: freq_pick = 34'd32768;
                4: freq_pick = {2'($urandom_range(0, 3)), $urandom};
                5: freq_pick = 34'd3;
                6: freq_pick = 34'd19200000;
                7: freq_pick = tte_pkg::FREQ_RESET;
                default: freq_pick = tte_pkg::FREQ_W'($urandom_range(1, 100000));
            endcase
            if (freq_pick == '0 && p != 2)
                freq_pick = 34'd1;
            write_freq(freq_pick);

            n_items = (p == 2) ? 30 : 134;
            for (int i = 0; i < n_items; i++)
            begin
                // spread of magnitudes, some behind the epoch, some fully random
                raw  = {$urandom, $urandom};
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    delta = raw >> $urandom_range(0, 63);
                else if (pick < 8)
                    delta = -(raw >> $urandom_range(20, 63));
                else
                    delta = raw;
                offer_query(epoch_tick + delta, tte_pkg::OP_W'($urandom_range(0, 7)));
            end
        end

        wait_drained();
        repeat (SETTLE) @(posedge clk);

        $display("covered %0d queries, %0d answers, %0d tick_freq settings from 0 to full scale",
                 queries_sent, board.answers, settings_used);
        $display("all eight unit codes, counters behind the epoch, mixed idling, %0d-cycle hold",
                 HOLD_CYCLES);
        if (board.errors == 0 && board.pending() == 0)
            $display("PASS tick_to_elapsed_time_converter");
        else
            $display("FAIL tick_to_elapsed_time_converter");
        $finish;
    end

endmodule
